// ===== hw/rtl/thermal_cycler_hold_controller_assert.svh =====
// Assertion macros used by the checker file of the thermal cycler hold controller.
`ifndef THERMAL_CYCLER_HOLD_CONTROLLER_ASSERT_SVH
`define THERMAL_CYCLER_HOLD_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tchc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tchc check failed");

`endif

// ===== hw/rtl/tchc_pkg.sv =====
// Shared types and constants of the thermal cycler hold controller.
package tchc_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input opcodes.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // Phase codes.
    localparam logic [1:0] PH_DENATURE = 2'd0;
    localparam logic [1:0] PH_ANNEAL   = 2'd1;
    localparam logic [1:0] PH_EXTEND   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DEN_TEMP  = 3'd0;
    localparam logic [2:0] CFG_DEN_SECS  = 3'd1;
    localparam logic [2:0] CFG_ANN_TEMP  = 3'd2;
    localparam logic [2:0] CFG_ANN_SECS  = 3'd3;
    localparam logic [2:0] CFG_EXT_TEMP  = 3'd4;
    localparam logic [2:0] CFG_EXT_SECS  = 3'd5;
    localparam logic [2:0] CFG_CYC_TOTAL = 3'd6;

    // Control law constants, temperatures in whole degrees.
    localparam logic [7:0] DUTY_OFF      = 8'd255;
    localparam logic [7:0] DUTY_FAN_HOT  = 8'd240;
    localparam logic [7:0] DUTY_HOLD     = 8'd192;
    localparam logic [7:0] DUTY_HOLD_HOT = 8'd120;
    localparam logic [7:0] BASE_NORMAL   = 8'd160;
    localparam logic [7:0] BASE_HOT      = 8'd128;
    localparam logic [7:0] TEMP_HOT      = 8'd85;
    localparam logic [7:0] TEMP_COOL     = 8'd60;
    localparam logic [7:0] TEMP_FAN      = 8'd90;
    localparam logic [8:0] HSC_MAX       = 9'd511;

    typedef enum logic [1:0] {
        K_SAMPLE = 2'd0,
        K_TICK   = 2'd1,
        K_START  = 2'd2,
        K_NOP    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [SAMPLE_W-1:0]  sample;
    } t_item;

    typedef struct packed {
        logic [7:0] denature_temp;
        logic [7:0] denature_secs;
        logic [7:0] anneal_temp;
        logic [7:0] anneal_secs;
        logic [7:0] extend_temp;
        logic [7:0] extend_secs;
        logic [7:0] cycle_total;
    } t_cfg;

endpackage

// ===== hw/rtl/tchc_in_if.sv =====
// Input channel of the thermal cycler hold controller: opcode and temperature sample.
interface tchc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [11:0] sample_temp;

    modport source (output valid, output opcode, output sample_temp, input ready);
    modport sink   (input valid, input opcode, input sample_temp, output ready);
endinterface

// ===== hw/rtl/tchc_out_if.sv =====
// Result channel of the thermal cycler hold controller: heater, fan and run status.
interface tchc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] heater_duty;
    logic       fan_on;
    logic       window_ok;
    logic [1:0] phase_now;
    logic [7:0] cycle_now;
    logic       run_done;

    modport source (output valid, output heater_duty, output fan_on, output window_ok,
                    output phase_now, output cycle_now, output run_done, input ready);
    modport sink   (input valid, input heater_duty, input fan_on, input window_ok,
                    input phase_now, input cycle_now, input run_done, output ready);
endinterface

// ===== hw/rtl/tchc_regs.sv =====
// Configuration register file with write port and reset defaults.
module tchc_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_wdata,
    output tchc_pkg::t_cfg o_cfg
);
    import tchc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.denature_temp <= 8'd95;
            r_cfg.denature_secs <= 8'd30;
            r_cfg.anneal_temp   <= 8'd55;
            r_cfg.anneal_secs   <= 8'd30;
            r_cfg.extend_temp   <= 8'd72;
            r_cfg.extend_secs   <= 8'd60;
            r_cfg.cycle_total   <= 8'd30;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEN_TEMP:  r_cfg.denature_temp <= i_cfg_wdata;
                CFG_DEN_SECS:  r_cfg.denature_secs <= i_cfg_wdata;
                CFG_ANN_TEMP:  r_cfg.anneal_temp   <= i_cfg_wdata;
                CFG_ANN_SECS:  r_cfg.anneal_secs   <= i_cfg_wdata;
                CFG_EXT_TEMP:  r_cfg.extend_temp   <= i_cfg_wdata;
                CFG_EXT_SECS:  r_cfg.extend_secs   <= i_cfg_wdata;
                CFG_CYC_TOTAL: r_cfg.cycle_total   <= i_cfg_wdata;
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== hw/rtl/tchc_front.sv =====
// Front end: accepts input beats and classifies the opcode into a queue item.
module tchc_front (
    tchc_in_if.sink        i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output tchc_pkg::t_item o_item
);
    import tchc_pkg::*;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_item.sample = i_in.sample_temp;
        unique case (i_in.opcode)
            OP_SAMPLE: o_item.kind = K_SAMPLE;
            OP_TICK:   o_item.kind = K_TICK;
            OP_START:  o_item.kind = K_START;
            default:   o_item.kind = K_NOP;
        endcase
    end
endmodule

// ===== hw/rtl/tchc_queue.sv =====
// Small FIFO that decouples the front end from the execution back end.
module tchc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tchc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tchc_pkg::t_item o_item
);
    import tchc_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== hw/rtl/tchc_back.sv =====
// Back end: executes queued items, keeps the run state and registers each result.
module tchc_back #(
    parameter int MAX_SAMPLES = 1023,
    parameter int FRAC_BITS   = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tchc_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  tchc_pkg::t_item i_q_item,
    output logic            o_q_pop,
    tchc_out_if.source      o_out
);
    import tchc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int CW    = SAMPLE_W + 2 + FRAC_BITS;
    localparam int VW    = SAMPLE_W + 3 + FRAC_BITS;
    localparam int XW    = SUM_W + 2 + FRAC_BITS;
    localparam int PW    = 8 + CNT_W;

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_SKIP = 2'b10
    } t_state;

    function automatic logic [7:0] f_target(t_cfg c, logic [1:0] ph);
        logic [7:0] t;
        case (ph)
            PH_ANNEAL: t = c.anneal_temp;
            PH_EXTEND: t = c.extend_temp;
            default:   t = c.denature_temp;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] f_secs(t_cfg c, logic [1:0] ph);
        logic [7:0] s;
        case (ph)
            PH_ANNEAL: s = c.anneal_secs;
            PH_EXTEND: s = c.extend_secs;
            default:   s = c.denature_secs;
        endcase
        return s;
    endfunction

    t_state            r_state, n_state;
    logic              r_running, n_running;
    logic [1:0]        r_phase, n_phase;
    logic [7:0]        r_cycle, n_cycle;
    logic [8:0]        r_hsc, n_hsc;
    logic              r_tick_pend, n_tick_pend;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_win, n_win;
    logic [7:0]        r_duty, n_duty;
    logic              r_fan, n_fan;

    logic              r_out_valid;
    logic [7:0]        r_out_duty;
    logic              r_out_fan;
    logic              r_out_win;
    logic [1:0]        r_out_phase;
    logic [7:0]        r_out_cycle;
    logic              r_out_done;

    logic [7:0]        t_cur;
    logic [7:0]        secs_cur;
    logic [7:0]        secs_nxt;
    logic [SAMPLE_W-1:0] sample;
    logic              out_free;
    logic              adv;
    logic              chk;
    logic              need_skip;
    logic              emit;

    // Control law datapath.
    logic [8:0]            lo9;
    logic [CW-1:0]         s2_d, thr_lo, thr_hi, thr_fan;
    logic                  is_low, is_high, hot;
    logic signed [9:0]     bt;
    logic signed [VW-1:0]  v;
    logic [7:0]            duty_low, duty_high, duty_mid, duty_drive;

    // Window check datapath.
    logic [PW-1:0]         prod;
    logic [XW-1:0]         s2w, hi_n, lo_n;
    logic                  win_bad;

    logic [8:0]            hsc_inc;

    assign t_cur    = f_target(i_cfg, r_phase);
    assign secs_cur = f_secs(i_cfg, r_phase);
    assign sample   = i_q_item.sample;
    assign out_free = !r_out_valid || o_out.ready;
    assign hsc_inc  = (r_hsc == HSC_MAX) ? r_hsc : r_hsc + 9'd1;

    always_comb begin
        lo9     = {t_cur, 1'b0} - 9'd1;
        s2_d    = CW'({sample, 1'b0});
        thr_lo  = CW'(lo9) << FRAC_BITS;
        thr_hi  = CW'({t_cur, 1'b1}) << FRAC_BITS;
        thr_fan = CW'(TEMP_FAN) << FRAC_BITS;
        is_low  = (t_cur != 8'd0) && (s2_d < thr_lo);
        is_high = s2_d > thr_hi;
        hot     = t_cur > TEMP_HOT;
        bt      = $signed({2'b00, (hot ? BASE_HOT : BASE_NORMAL)}) - $signed({2'b00, t_cur});
        v       = (VW'(bt) <<< FRAC_BITS) + VW'($signed({1'b0, sample}));
        // A negative heating value saturates at full heat.
        duty_low  = (v[VW-1] || (v == '0)) ? 8'd0 : v[FRAC_BITS +: 8];
        duty_high = (CW'(sample) > thr_fan) ? DUTY_FAN_HOT : DUTY_OFF;
        if (hot) begin
            duty_mid = DUTY_HOLD_HOT;
        end else if (t_cur < TEMP_COOL) begin
            duty_mid = DUTY_OFF;
        end else begin
            duty_mid = DUTY_HOLD;
        end
        if (is_low) begin
            duty_drive = duty_low;
        end else if (is_high) begin
            duty_drive = duty_high;
        end else begin
            duty_drive = duty_mid;
        end
    end

    // Mean versus target +/-1.5 degrees, cross-multiplied by the count.
    always_comb begin
        prod    = PW'(t_cur) * PW'(r_cnt);
        s2w     = XW'({r_sum, 1'b0});
        hi_n    = XW'({prod, 1'b0}) + XW'({r_cnt, 1'b0}) + XW'(r_cnt);
        lo_n    = XW'({prod, 1'b0}) - XW'({r_cnt, 1'b0}) - XW'(r_cnt);
        win_bad = (r_cnt != '0) &&
                  ((s2w >= (hi_n << FRAC_BITS)) ||
                   ((t_cur >= 8'd2) && (s2w <= (lo_n << FRAC_BITS))));
    end

    always_comb begin
        n_state     = r_state;
        n_running   = r_running;
        n_phase     = r_phase;
        n_cycle     = r_cycle;
        n_hsc       = r_hsc;
        n_tick_pend = r_tick_pend;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_win       = r_win;
        n_duty      = r_duty;
        n_fan       = r_fan;
        o_q_pop     = 1'b0;
        adv         = 1'b0;
        chk         = 1'b0;
        emit        = 1'b0;

        unique case (r_state)
            ST_EXEC: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.kind)
                        K_SAMPLE: begin
                            if (r_running) begin
                                n_duty = duty_drive;
                                n_fan  = is_high && !is_low;
                                if (r_tick_pend) begin
                                    n_tick_pend = 1'b0;
                                    n_win       = !win_bad;
                                    n_sum       = '0;
                                    n_cnt       = '0;
                                    if (win_bad) begin
                                        n_hsc = '0;
                                    end
                                end else if (r_cnt < CNT_W'(MAX_SAMPLES)) begin
                                    n_sum = r_sum + SUM_W'(sample);
                                    n_cnt = r_cnt + 1'b1;
                                end
                            end
                        end
                        K_TICK: begin
                            n_tick_pend = 1'b1;
                            chk         = 1'b1;
                            if (r_running) begin
                                n_hsc = hsc_inc;
                                adv   = (hsc_inc >= {secs_cur, 1'b0});
                            end
                        end
                        K_START: begin
                            n_running = (i_cfg.cycle_total != 8'd0);
                            n_phase   = PH_DENATURE;
                            n_cycle   = '0;
                            n_hsc     = '0;
                            n_sum     = '0;
                            n_cnt     = '0;
                            chk       = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SKIP: begin
                adv = 1'b1;
                chk = 1'b1;
            end
            default: begin
                n_state = ST_EXEC;
            end
        endcase

        // Phase end.
        if (adv) begin
            n_hsc  = '0;
            n_sum  = '0;
            n_cnt  = '0;
            n_duty = DUTY_OFF;
            n_fan  = 1'b0;
            if (n_phase == PH_EXTEND) begin
                n_phase = PH_DENATURE;
                n_cycle = n_cycle + 8'd1;
                if (n_cycle >= i_cfg.cycle_total) begin
                    n_running = 1'b0;
                end
            end else begin
                n_phase = n_phase + 2'd1;
            end
        end

        // Zero-length phases are passed over one per cycle.
        secs_nxt  = f_secs(i_cfg, n_phase);
        need_skip = chk && n_running && (n_hsc >= {secs_nxt, 1'b0});

        if (r_state == ST_SKIP) begin
            if (!need_skip) begin
                emit    = 1'b1;
                n_state = ST_EXEC;
            end
        end else if (o_q_pop) begin
            if (need_skip) begin
                n_state = ST_SKIP;
            end else begin
                emit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_EXEC;
            r_running   <= 1'b0;
            r_phase     <= PH_DENATURE;
            r_cycle     <= '0;
            r_hsc       <= '0;
            r_tick_pend <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_win       <= 1'b0;
            r_duty      <= DUTY_OFF;
            r_fan       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_phase     <= n_phase;
            r_cycle     <= n_cycle;
            r_hsc       <= n_hsc;
            r_tick_pend <= n_tick_pend;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_win       <= n_win;
            r_duty      <= n_duty;
            r_fan       <= n_fan;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_duty  <= n_duty;
            r_out_fan   <= n_fan;
            r_out_win   <= n_win;
            r_out_phase <= n_phase;
            r_out_cycle <= n_cycle;
            r_out_done  <= !n_running;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.heater_duty = r_out_duty;
    assign o_out.fan_on      = r_out_fan;
    assign o_out.window_ok   = r_out_win;
    assign o_out.phase_now   = r_out_phase;
    assign o_out.cycle_now   = r_out_cycle;
    assign o_out.run_done    = r_out_done;
endmodule

// ===== hw/rtl/thermal_cycler_hold_controller.sv =====
// Top level of the thermal cycler hold controller: registers, front end, queue and back end.
//
//   Channel   Direction  Beat contents
//   --------  ---------  ---------------------------------------------------------
//   i_in      in         opcode, sample_temp (sample, half-second tick, start)
//   o_out     out        heater_duty, fan_on, window_ok, phase_now, cycle_now, run_done
//   i_cfg_*   in         register index and 8-bit value, written on i_cfg_we
//
// Every input beat produces exactly one result beat. In steady flow, with results taken
// and no phase passed over, one beat is taken and one result is delivered per cycle,
// through the queue and the result register. A tick that ends a phase, or a start,
// holds the back end in its skip state while zero-length phases are passed over; the
// back end steps one phase per cycle through the sequencer. Reset is synchronous and
// active low and loads the default recipe; there is no clearing pass. The four-entry
// queue and the result register let either side stall without stopping the other.
module thermal_cycler_hold_controller #(
    parameter int MAX_SAMPLES = 1023,
    parameter int FRAC_BITS   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tchc_in_if.sink     i_in,
    tchc_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);
    import tchc_pkg::*;

    // Recipe registers, shared by the whole back end.
    t_cfg  cfg;

    // Front end to queue.
    logic  push;
    t_item push_item;
    logic  q_full;

    // Queue to back end.
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    tchc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // The front end accepts a beat whenever the queue has room.
    tchc_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (push_item)
    );

    tchc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // The back end runs the control law, the window check and the phase sequencer,
    // and holds each result in its output register until it is taken.
    tchc_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );
endmodule

// ===== hw/rtl/tchc_checker.sv =====
// Port-level checker of the thermal cycler hold controller and its bind statement.
`include "thermal_cycler_hold_controller_assert.svh"

module tchc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_heater_duty,
    input logic       i_fan_on,
    input logic [1:0] i_phase_now,
    input logic       i_run_done
);
    import tchc_pkg::*;

    // A stalled result beat stays offered.
    `TCHC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_heater_duty) && $stable(i_phase_now))

    // An idle or finished run always reports the first phase.
    `TCHC_ASSERT_IMPLY(a_idle_phase, i_clk, i_rst_n, i_out_valid && i_run_done, i_phase_now == PH_DENATURE)

    // The fan only runs with the heater off or at its hot idle value.
    `TCHC_ASSERT_IMPLY(a_fan_duty, i_clk, i_rst_n, i_out_valid && i_fan_on, i_heater_duty == DUTY_OFF || i_heater_duty == DUTY_FAN_HOT)

    // The phase counter never reaches the unused code.
    `TCHC_ASSERT_IMPLY(a_phase_code, i_clk, i_rst_n, i_out_valid, i_phase_now == PH_DENATURE || i_phase_now == PH_ANNEAL || i_phase_now == PH_EXTEND)
endmodule

bind thermal_cycler_hold_controller tchc_checker u_tchc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_heater_duty (o_out.heater_duty),
    .i_fan_on      (o_out.fan_on),
    .i_phase_now   (o_out.phase_now),
    .i_run_done    (o_out.run_done)
);
